### design/encoder_electric_angle_comp_top_macros.svh
// Assertion macros used by the port-level checker of the angle compensation block.
`ifndef ENCODER_ELECTRIC_ANGLE_COMP_TOP_MACROS_SVH
`define ENCODER_ELECTRIC_ANGLE_COMP_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ECAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ECAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ecac_pkg.sv
// Types and constants shared by the encoder electric angle compensation block.
package ecac_pkg;

  localparam int ERR_W       = 16;
  localparam int POLE_W      = 6;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int OFFSET_W    = 16;

  localparam logic [POLE_W-1:0] PP_COUNT_RESET = 6'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MECH_OFFSET = 2'd0,
    CFG_PP_COUNT    = 2'd1,
    CFG_DIR_INVERT  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_SAMPLE      = 1'b0,
    OP_TABLE_WRITE = 1'b1
  } op_t;

endpackage

### design/ecac_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module ecac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

### design/encoder_electric_angle_comp_top.sv
// Top level of the encoder electric angle compensation block.
//
// Input stream (s_*): one item per handshake. s_tuser is the op: a sample
// turns enc_angle into a mechanical angle, a raw electrical angle and a
// compensated electrical angle; a table write loads entry_value into the
// error table at entry_index and gives no result.
// Output stream (m_*): one item per sample, in input order.
// Configuration: cfg_we writes cfg_data into register cfg_index (mech_offset,
// pp_count, dir_invert); write only while no item is in flight.
// Pipeline: input register, table read register, output register. A sample
// passes them in that order and appears on m_tvalid once the output is free.
// Throughput, with no output stall, is one item per cycle, set by the dual-read
// table memory and the single interpolation multiplier in the middle stage.
// When m_tready is low the output item holds and the earlier stages keep
// filling; s_tready drops only once all three stages are full.
// Reset clears the stage valid bits and the registers to their defaults;
// the error table is not cleared and an entry must be written before use.
module encoder_electric_angle_comp_top
  import ecac_pkg::*;
#(
  parameter int LUT_ENTRIES = 64,
  parameter int ANGLE_BITS  = 16,
  localparam int IDX_W       = $clog2(LUT_ENTRIES),
  localparam int IN_FIELDS_W = ANGLE_BITS + IDX_W + ERR_W,
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((3 * ANGLE_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // enc_angle, entry_index, entry_value
  input  logic                   s_tuser,   // op
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // mech_angle, elec_angle_raw, elec_angle_comp
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AB     = ANGLE_BITS;
  localparam int OFF_XW = (AB > OFFSET_W) ? AB : OFFSET_W;
  localparam int POS_W  = AB + IDX_W;
  localparam int SUM_W  = (AB > ERR_W + 2) ? AB : ERR_W + 2;
  localparam int PROD_W = ERR_W + 1 + AB + 1;

  // configuration
  logic [OFFSET_W-1:0] mech_offset;
  logic [POLE_W-1:0]   pp_count;
  logic                dir_invert;

  always_ff @(posedge clk) begin
    if (rst) begin
      mech_offset <= '0;
      pp_count    <= PP_COUNT_RESET;
      dir_invert  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MECH_OFFSET: mech_offset <= cfg_data[OFFSET_W-1:0];
        CFG_PP_COUNT:    pp_count    <= cfg_data[POLE_W-1:0];
        CFG_DIR_INVERT:  dir_invert  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage flow
  logic a_valid, b_valid, o_valid;
  logic ready_o, ready_b, ready_a;

  assign ready_o  = !o_valid || m_tready;
  assign ready_b  = !b_valid || ready_o;
  assign ready_a  = !a_valid || ready_b;
  assign s_tready = ready_a;

  // stage A: input register
  op_t                     a_op;
  logic [AB-1:0]           a_angle;
  logic [IDX_W-1:0]        a_index;
  logic [ERR_W-1:0]        a_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (ready_a) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && s_tvalid) begin
      a_op    <= op_t'(s_tuser);
      a_angle <= s_tdata[AB-1:0];
      a_index <= s_tdata[AB+IDX_W-1:AB];
      a_value <= s_tdata[AB+IDX_W+ERR_W-1:AB+IDX_W];
    end
  end

  logic [OFF_XW-1:0]      off_wide;
  logic [AB-1:0]          mech_a;
  logic [AB+POLE_W-1:0]   elec_prod;
  logic [AB-1:0]          raw_a;
  logic [POS_W-1:0]       pos_a;
  logic [IDX_W-1:0]       idx0_a, idx1_a;
  logic                   wr_en;

  assign off_wide  = OFF_XW'(mech_offset);
  assign mech_a    = a_angle - off_wide[AB-1:0];
  assign elec_prod = (AB+POLE_W)'(mech_a) * (AB+POLE_W)'(pp_count);
  assign raw_a     = dir_invert ? (AB'(0) - elec_prod[AB-1:0]) : elec_prod[AB-1:0];
  assign pos_a     = POS_W'(mech_a) * POS_W'(LUT_ENTRIES);
  assign idx0_a    = pos_a[POS_W-1:AB];
  assign idx1_a    = (idx0_a == IDX_W'(LUT_ENTRIES - 1)) ? '0 : idx0_a + IDX_W'(1);
  assign wr_en     = a_valid && (a_op == OP_TABLE_WRITE) && ready_b &&
                     ({1'b0, a_index} < (IDX_W+1)'(LUT_ENTRIES));

  logic [ERR_W-1:0] e0_b, e1_b;

  ecac_ram #(
    .WIDTH (ERR_W),
    .DEPTH (LUT_ENTRIES)
  ) u_table (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (a_index),
    .wdata  (a_value),
    .re     (ready_b),
    .raddr0 (idx0_a),
    .raddr1 (idx1_a),
    .rdata0 (e0_b),
    .rdata1 (e1_b)
  );

  // stage B: table data and interpolation
  logic [AB-1:0] b_mech, b_raw, b_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (ready_b) begin
      b_valid <= a_valid && (a_op == OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b) begin
      b_mech <= mech_a;
      b_raw  <= raw_a;
      b_frac <= pos_a[AB-1:0];
    end
  end

  logic signed [ERR_W:0]    diff_b;
  logic signed [PROD_W-1:0] interp_prod;
  logic signed [PROD_W-1:0] interp_shift;
  logic signed [ERR_W+1:0]  err_b;
  logic [SUM_W-1:0]         comp_sum;

  assign diff_b       = $signed({e1_b[ERR_W-1], e1_b}) - $signed({e0_b[ERR_W-1], e0_b});
  assign interp_prod  = PROD_W'(diff_b) * PROD_W'($signed({1'b0, b_frac}));
  assign interp_shift = interp_prod >>> AB;
  assign err_b        = (ERR_W+2)'($signed(e0_b)) + interp_shift[ERR_W+1:0];
  assign comp_sum     = SUM_W'(b_raw) + SUM_W'(err_b);

  // output register
  logic [AB-1:0] o_mech, o_raw, o_comp;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (ready_o) begin
      o_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && b_valid) begin
      o_mech <= b_mech;
      o_raw  <= b_raw;
      o_comp <= comp_sum[AB-1:0];
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = OUT_TDATA_W'({o_comp, o_raw, o_mech});

endmodule

### design/ecac_checker.sv
// Port-level checker for the encoder electric angle compensation block, with its bind.
`include "encoder_electric_angle_comp_top_macros.svh"

module ecac_checker
  import ecac_pkg::*;
#(
  parameter int OUT_W = 48
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             s_tuser,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic sample_acc;
  logic out_stall;

  assign sample_acc = s_tvalid && s_tready && (s_tuser == OP_SAMPLE);
  assign out_stall  = m_tvalid && !m_tready;

  `ECAC_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled item moved")
  `ECAC_ASSERT_NOW(a_in_backpressure, !s_tready, out_stall, "input stall without output stall")
  `ECAC_ASSERT_NOW(a_reset_empty, $past(rst), !m_tvalid, "output valid straight after reset")
  `ECAC_ASSERT_NEXT(a_latency, sample_acc ##1 m_tready ##1 m_tready, m_tvalid, "late result")

endmodule

bind encoder_electric_angle_comp_top ecac_checker #(
  .OUT_W (OUT_TDATA_W)
) u_ecac_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/ecac_angle_checker.sv
// Checker for the encoder angle compensation block: predicts each result and compares it.
module ecac_angle_checker
  import ecac_pkg::*;
#(
  parameter int IN_TDATA_W  = 40,
  parameter int OUT_TDATA_W = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending,
  output int                     checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 64;

  // mech_angle sits in the lowest bits
  typedef struct packed {
    logic [15:0] comp;
    logic [15:0] raw;
    logic [15:0] mech;
  } angle_set_t;

  logic signed [15:0] err_table [TABLE_DEPTH];
  logic [15:0]        offset_q;
  logic [5:0]         pole_q;
  logic               reverse_q;
  angle_set_t         angle_q[$];
  angle_set_t         want;
  angle_set_t         got;
  int                 errors;
  int                 n_checked;

  function automatic angle_set_t compensate_angle(logic [15:0] enc);
    logic [15:0] mech;
    logic [15:0] raw;
    logic [5:0]  idx0;
    logic [5:0]  idx1;
    longint      frac;
    longint      e0;
    longint      e1;
    longint      err;
    angle_set_t  r;
    mech = enc - offset_q;
    raw  = mech * {10'd0, pole_q};
    if (reverse_q) begin
      raw = 16'd0 - raw;
    end
    idx0 = mech[15:10];
    idx1 = idx0 + 6'd1;
    frac = {mech[9:0], 6'd0};
    e0   = err_table[idx0];
    e1   = err_table[idx1];
    err  = e0 + (((e1 - e0) * frac) >>> 16);
    r.mech = mech;
    r.raw  = raw;
    r.comp = raw + err[15:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors     = 0;
    n_checked  = 0;
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      offset_q  = '0;
      pole_q    = PP_COUNT_RESET;
      reverse_q = 1'b0;
      angle_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = angle_set_t'(m_tdata[47:0]);
        if (angle_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h", $time, got);
          errors++;
        end else begin
          want = angle_q.pop_front();
          check_field("mech_angle", want.mech, got.mech);
          check_field("elec_angle_raw", want.raw, got.raw);
          check_field("elec_angle_comp", want.comp, got.comp);
          n_checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        if (op_t'(s_tuser) == OP_TABLE_WRITE) begin
          err_table[s_tdata[21:16]] = s_tdata[37:22];
        end else begin
          angle_q.push_back(compensate_angle(s_tdata[15:0]));
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_MECH_OFFSET: offset_q = cfg_data[15:0];
          CFG_PP_COUNT:    pole_q = cfg_data[5:0];
          CFG_DIR_INVERT:  reverse_q = cfg_data[0];
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending    <= angle_q.size();
    checked    <= n_checked;
  end

endmodule

### tb/tb_encoder_electric_angle_comp_top.sv
// Testbench top for the encoder angle compensation block: stimulus, flow control and verdict.
module tb_encoder_electric_angle_comp_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ecac_pkg::*;

  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 48;
  localparam int N_PHASES      = 6;
  localparam int RANDOM_ITEMS  = 162;
  localparam int SETTLE_CYCLES = 8;
  localparam int SQUEEZE_LEN   = 80;
  localparam int CYCLE_LIMIT   = 200000;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // enc_angle, entry_index, entry_value
  logic                   s_tuser;   // op
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // mech_angle, elec_angle_raw, elec_angle_comp
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int          fail_count;
  int          pending;
  int          checked;
  int unsigned cycle_count;
  int          burst_left;
  int          n_samples;
  int          n_writes;
  logic        squeeze_req;
  logic        squeeze_done;

  encoder_electric_angle_comp_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ecac_angle_checker #(
    .IN_TDATA_W  (IN_TDATA_W),
    .OUT_TDATA_W (OUT_TDATA_W)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stall pattern, plus one long hold-off on request.
  initial begin
    int seg_left;
    int mode;
    int hold_left;
    m_tready     = 1'b0;
    squeeze_done = 1'b0;
    seg_left     = 0;
    mode         = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (squeeze_req && !squeeze_done) begin
          squeeze_done = 1'b1;
          hold_left    = SQUEEZE_LEN;
        end
        if (hold_left > 0) begin
          m_tready <= 1'b0;
          hold_left--;
        end else begin
          if (seg_left == 0) begin
            mode     = $urandom_range(0, 3);
            seg_left = $urandom_range(10, 60);
          end
          seg_left--;
          case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  task automatic send_item(op_t op, logic [15:0] angle, logic [5:0] idx, logic [15:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, value, idx, angle};
    do @(posedge clk); while (!s_tready);
    if (op == OP_TABLE_WRITE) begin
      n_writes++;
    end else begin
      n_samples++;
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] offset, logic [5:0] pp, logic rev);
    write_reg(CFG_MECH_OFFSET, offset);
    write_reg(CFG_PP_COUNT, {10'd0, pp});
    write_reg(CFG_DIR_INVERT, {15'd0, rev});
    cfg_we <= 1'b0;
  endtask

  // Hold the input idle until every result is back, then let the pipe settle.
  task automatic drain();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_error();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 63)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_item();
    if ($urandom_range(0, 3) == 0) begin
      send_item(OP_TABLE_WRITE, 16'($urandom), 6'($urandom_range(0, 63)), pick_error());
    end else begin
      send_item(OP_SAMPLE, 16'($urandom), 6'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] fill_v;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = OP_SAMPLE;
    cfg_we       = 1'b0;
    cfg_index    = CFG_MECH_OFFSET;
    cfg_data     = '0;
    squeeze_req  = 1'b0;
    burst_left   = 0;
    n_samples    = 0;
    n_writes     = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0: set_config(16'd0, 6'd7, 1'b0);
        1: set_config(16'hFFFF, 6'd63, 1'b1);
        2: set_config(16'($urandom), 6'd1, 1'b0);
        3: set_config(16'($urandom), 6'd0, 1'b1);
        4: set_config(16'($urandom), 6'($urandom_range(1, 63)), 1'b0);
        default: set_config(16'($urandom), 6'($urandom_range(1, 63)), 1'b1);
      endcase
      if (ph == 0) begin
        // load every entry before the first sample, extremes at the wrap
        for (int i = 0; i < 64; i++) begin
          case (i)
            0:  fill_v = 16'h7FFF;
            1:  fill_v = 16'h8000;
            63: fill_v = 16'h8000;
            default: fill_v = pick_error();
          endcase
          send_item(OP_TABLE_WRITE, 16'($urandom), 6'(i), fill_v);
        end
        send_item(OP_SAMPLE, 16'h0000, 6'd0, 16'h0000);
        send_item(OP_SAMPLE, 16'h0001, 6'd63, 16'hFFFF);
        send_item(OP_SAMPLE, 16'h03FF, 6'd0, 16'h0000);
        send_item(OP_SAMPLE, 16'h0400, 6'd0, 16'h0000);
        send_item(OP_SAMPLE, 16'h7FFF, 6'd0, 16'h0000);
        send_item(OP_SAMPLE, 16'h8000, 6'd0, 16'h0000);
        send_item(OP_SAMPLE, 16'hFC00, 6'd0, 16'h0000);
        send_item(OP_SAMPLE, 16'hFFFF, 6'd0, 16'h0000);
        send_item(OP_TABLE_WRITE, 16'hFFFF, 6'd0, 16'h8000);
        send_item(OP_TABLE_WRITE, 16'h0000, 6'd63, 16'h7FFF);
        send_item(OP_SAMPLE, 16'hFFFF, 6'd0, 16'h0000);
        send_item(OP_SAMPLE, 16'hFFC0, 6'd0, 16'h0000);
        send_item(OP_SAMPLE, 16'h0001, 6'd0, 16'h0000);
      end else if (ph == 1) begin
        send_item(OP_SAMPLE, 16'h0000, 6'd0, 16'h0000);
        send_item(OP_SAMPLE, 16'hFFFF, 6'd0, 16'h0000);
        send_item(OP_SAMPLE, 16'h0400, 6'd0, 16'h0000);
        send_item(OP_SAMPLE, 16'h8000, 6'd0, 16'h0000);
      end else if (ph == 2) begin
        squeeze_req = 1'b1;
      end
      repeat (RANDOM_ITEMS) random_item();
    end

    drain();
    $display("Covered %0d angle samples and %0d table writes over %0d register settings,",
             n_samples, n_writes, N_PHASES);
    $display("including offset and index wrap, zero pole pairs and reversed direction.");
    if (fail_count == 0 && pending == 0 && checked == n_samples) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/ecac_pkg.sv
design/ecac_ram.sv
design/encoder_electric_angle_comp_top.sv
design/ecac_checker.sv
tb/ecac_angle_checker.sv
tb/tb_encoder_electric_angle_comp_top.sv
